// ===== hw/rtl/hbp_pkg.sv =====
// ----------------------------------------------------------------------------
// hbp_pkg
// Shared types and fixed field widths of the hash bucket partitioner.
// ----------------------------------------------------------------------------
package hbp_pkg;

   localparam int BYTE_BITS   = 8;
   localparam int HASH_W      = 64;
   localparam int DRAIN_W     = 8;
   localparam int INDEX_W     = 14;
   localparam int SUFFIX_W    = 56;
   localparam int NONCE_W     = 40;

   localparam int REQ_TDATA_W = 72;
   localparam int REQ_TUSER_W = 1;
   localparam int RSP_TDATA_W = 112;
   localparam int RSP_TUSER_W = 2;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_DRAIN  = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PROC,
      ST_FLUSH,
      ST_OVF
   } state_type;

endpackage

// ===== hw/rtl/hbp_ram.sv =====
// ----------------------------------------------------------------------------
// hbp_ram
// Simple dual-port RAM: one write port, one read port with registered data
// that holds its value while no read is issued.
// ----------------------------------------------------------------------------
module hbp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/hash_bucket_partitioner.sv =====
// ----------------------------------------------------------------------------
// hash_bucket_partitioner
// Sorts hashes into prefix buckets and emits full or drained buckets as indexed runs.
// ----------------------------------------------------------------------------
// Each request is handled alone. An insert reads the bucket's fill and flush
// counts from the bucket memory in its acceptance cycle and writes the entry
// and the updated counts back in the next cycle. An insert that fills its
// bucket, and a drain, then stream ENTRIES_PER_BUCKET results out of the entry
// memory at one per cycle, paced by rsp_tready; a bucket with no free flush
// slot instead gives one overflow result. After reset all 2**(8*PREFIX_BYTES)
// buckets (256 by default) of the bucket memory are cleared before the first
// request is taken.
// ----------------------------------------------------------------------------
module hash_bucket_partitioner
   import hbp_pkg::*;
#(
   parameter int HASH_BYTES         = 8,
   parameter int PREFIX_BYTES       = 1,
   parameter int ENTRIES_PER_BUCKET = 16,
   parameter int FLUSH_SLOTS        = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // hash_value[63:0], drain_bucket[71:64]
   input  logic [REQ_TUSER_W-1:0] req_tuser,  // operation[0]
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,  // disk_entry_index[13:0],
                                              // entry_suffix[69:14],
                                              // entry_nonce[109:70], zero[111:110]
   output logic [RSP_TUSER_W-1:0] rsp_tuser,  // entry_valid[0], bucket_overflow[1]
   output logic                   rsp_tlast   // last_of_run
);

   localparam int BKT_W        = BYTE_BITS * PREFIX_BYTES;
   localparam int BUCKET_COUNT = 1 << BKT_W;
   localparam int SUFFIX_BITS  = BYTE_BITS * (HASH_BYTES - PREFIX_BYTES);
   localparam int SUF_W        = (SUFFIX_BITS > 0) ? SUFFIX_BITS : 1;
   localparam int FILL_W       = $clog2(ENTRIES_PER_BUCKET);
   localparam int CNT_W        = FILL_W + 1;
   localparam int FLUSH_W      = $clog2(FLUSH_SLOTS + 1);
   localparam int META_W       = FLUSH_W + FILL_W;
   localparam int ENTRY_W      = SUF_W + NONCE_W;
   localparam int ENTRY_DEPTH  = BUCKET_COUNT * ENTRIES_PER_BUCKET;
   localparam int EADDR_W      = $clog2(ENTRY_DEPTH);
   localparam int BUCKET_SPAN  = FLUSH_SLOTS * ENTRIES_PER_BUCKET;

   state_type state_ff, state_in;

   logic [BKT_W-1:0]   clr_ff, clr_in;
   logic               op_ff, op_in;
   logic [BKT_W-1:0]   bucket_ff, bucket_in;
   logic [SUF_W-1:0]   suffix_ff, suffix_in;
   logic [NONCE_W-1:0] nonce_ff, nonce_in;
   logic [CNT_W-1:0]   flush_fill_ff, flush_fill_in;
   logic [INDEX_W-1:0] base_ff, base_in;
   logic [CNT_W-1:0]   rd_pos_ff, rd_pos_in;
   logic               pend_ff, pend_in;
   logic [FILL_W-1:0]  pend_pos_ff, pend_pos_in;

   logic                out_valid_ff, out_valid_in;
   logic [INDEX_W-1:0]  out_index_ff, out_index_in;
   logic [SUFFIX_W-1:0] out_suffix_ff, out_suffix_in;
   logic [NONCE_W-1:0]  out_nonce_ff, out_nonce_in;
   logic                out_entry_valid_ff, out_entry_valid_in;
   logic                out_ovf_ff, out_ovf_in;
   logic                out_last_ff, out_last_in;

   logic               meta_wr_en;
   logic [BKT_W-1:0]   meta_wr_addr;
   logic [META_W-1:0]  meta_wr_data;
   logic               meta_rd_en;
   logic [META_W-1:0]  meta_rd_data;
   logic               entry_wr_en;
   logic [EADDR_W-1:0] entry_wr_addr;
   logic               entry_rd_en;
   logic [EADDR_W-1:0] entry_rd_addr;
   logic [ENTRY_W-1:0] entry_rd_data;

   logic               accept;
   logic [BKT_W-1:0]   req_bucket;
   logic [FILL_W-1:0]  cur_fill;
   logic [FLUSH_W-1:0] cur_slot;
   logic [CNT_W-1:0]   fill_inc;
   logic               do_flush;
   logic [CNT_W-1:0]   run_fill;
   logic               slots_used;
   logic               out_free;
   logic               load_entry;
   logic               issue_read;
   logic               run_done;
   logic               pend_is_valid;

   // ---------------------------------------------------------------- decode
   assign accept   = req_tvalid && req_tready;
   assign out_free = !out_valid_ff || rsp_tready;

   always_comb begin
      if (req_tuser[0] == OP_DRAIN) begin
         req_bucket = BKT_W'(req_tdata[HASH_W +: DRAIN_W]);
      end else begin
         req_bucket = req_tdata[SUFFIX_BITS +: BKT_W];
      end
      if (SUFFIX_BITS > 0) begin
         suffix_in = req_tdata[SUF_W-1:0];
      end else begin
         suffix_in = '0;
      end
   end

   assign op_in     = accept ? req_tuser[0] : op_ff;
   assign bucket_in = accept ? req_bucket : bucket_ff;

   assign cur_fill   = meta_rd_data[FILL_W-1:0];
   assign cur_slot   = meta_rd_data[META_W-1:FILL_W];
   assign fill_inc   = {1'b0, cur_fill} + CNT_W'(1);
   assign slots_used = (cur_slot >= FLUSH_W'(FLUSH_SLOTS));
   assign do_flush   = (op_ff == OP_DRAIN) || (fill_inc == CNT_W'(ENTRIES_PER_BUCKET));
   assign run_fill   = (op_ff == OP_DRAIN) ? {1'b0, cur_fill} : fill_inc;

   // ------------------------------------------------------------ flush loop
   assign load_entry    = (state_ff == ST_FLUSH) && pend_ff && out_free;
   assign issue_read    = (state_ff == ST_FLUSH)
                        && (rd_pos_ff < CNT_W'(ENTRIES_PER_BUCKET))
                        && (!pend_ff || load_entry);
   assign run_done      = load_entry && (pend_pos_ff == FILL_W'(ENTRIES_PER_BUCKET - 1));
   assign pend_is_valid = ({1'b0, pend_pos_ff} < flush_fill_ff);

   // ------------------------------------------------------------ next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_PROC;
            end
         end
         ST_PROC: begin
            if (!do_flush) begin
               state_in = ST_IDLE;
            end else if (slots_used) begin
               state_in = ST_OVF;
            end else begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (run_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_OVF: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // --------------------------------------------------------------- outputs
   always_comb begin
      req_tready    = 1'b0;
      clr_in        = clr_ff;
      meta_wr_en    = 1'b0;
      meta_wr_addr  = bucket_ff;
      meta_wr_data  = '0;
      meta_rd_en    = accept;
      entry_wr_en   = 1'b0;
      entry_wr_addr = EADDR_W'(int'(bucket_ff) * ENTRIES_PER_BUCKET + int'(cur_fill));
      entry_rd_en   = issue_read;
      entry_rd_addr = EADDR_W'(int'(bucket_ff) * ENTRIES_PER_BUCKET
                               + int'(rd_pos_ff[FILL_W-1:0]));
      nonce_in      = nonce_ff;
      flush_fill_in = flush_fill_ff;
      base_in       = base_ff;
      rd_pos_in     = rd_pos_ff;
      pend_in       = pend_ff;
      pend_pos_in   = pend_pos_ff;

      out_valid_in       = out_valid_ff && !rsp_tready;
      out_index_in       = out_index_ff;
      out_suffix_in      = out_suffix_ff;
      out_nonce_in       = out_nonce_ff;
      out_entry_valid_in = out_entry_valid_ff;
      out_ovf_in         = out_ovf_ff;
      out_last_in        = out_last_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            meta_wr_en   = 1'b1;
            meta_wr_addr = clr_ff;
            clr_in       = clr_ff + BKT_W'(1);
         end
         ST_IDLE: begin
            req_tready = 1'b1;
         end
         ST_PROC: begin
            meta_wr_en = 1'b1;
            if (op_ff == OP_INSERT) begin
               entry_wr_en = 1'b1;
               nonce_in    = nonce_ff + NONCE_W'(1);
            end
            if (!do_flush) begin
               meta_wr_data = {cur_slot, fill_inc[FILL_W-1:0]};
            end else if (slots_used) begin
               // drop the entries, keep the slot count
               meta_wr_data = {cur_slot, FILL_W'(0)};
            end else begin
               meta_wr_data  = {cur_slot + FLUSH_W'(1), FILL_W'(0)};
               flush_fill_in = run_fill;
               base_in       = INDEX_W'(int'(bucket_ff) * BUCKET_SPAN
                                        + int'(cur_slot) * ENTRIES_PER_BUCKET);
               rd_pos_in     = '0;
               pend_in       = 1'b0;
            end
         end
         ST_FLUSH: begin
            if (issue_read) begin
               rd_pos_in   = rd_pos_ff + CNT_W'(1);
               pend_in     = 1'b1;
               pend_pos_in = rd_pos_ff[FILL_W-1:0];
            end else if (load_entry) begin
               pend_in = 1'b0;
            end
            if (load_entry) begin
               out_valid_in       = 1'b1;
               out_index_in       = base_ff + INDEX_W'(pend_pos_ff);
               out_entry_valid_in = pend_is_valid;
               out_ovf_in         = 1'b0;
               out_last_in        = run_done;
               if (pend_is_valid) begin
                  out_suffix_in = SUFFIX_W'(entry_rd_data[SUF_W-1:0]);
                  out_nonce_in  = entry_rd_data[ENTRY_W-1:SUF_W];
               end else begin
                  out_suffix_in = '0;
                  out_nonce_in  = '0;
               end
            end
         end
         ST_OVF: begin
            if (out_free) begin
               out_valid_in       = 1'b1;
               out_index_in       = '0;
               out_suffix_in      = '0;
               out_nonce_in       = '0;
               out_entry_valid_in = 1'b0;
               out_ovf_in         = 1'b1;
               out_last_in        = 1'b1;
            end
         end
         default: ;
      endcase
   end

   // ------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         nonce_ff     <= '0;
         pend_ff      <= 1'b0;
         rd_pos_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         nonce_ff     <= nonce_in;
         pend_ff      <= pend_in;
         rd_pos_ff    <= rd_pos_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff              <= op_in;
      bucket_ff          <= bucket_in;
      if (accept) begin
         suffix_ff <= suffix_in;
      end
      flush_fill_ff      <= flush_fill_in;
      base_ff            <= base_in;
      pend_pos_ff        <= pend_pos_in;
      out_index_ff       <= out_index_in;
      out_suffix_ff      <= out_suffix_in;
      out_nonce_ff       <= out_nonce_in;
      out_entry_valid_ff <= out_entry_valid_in;
      out_ovf_ff         <= out_ovf_in;
      out_last_ff        <= out_last_in;
   end

   // -------------------------------------------------------------- memories
   hbp_ram #(
      .WIDTH (META_W),
      .DEPTH (BUCKET_COUNT)
   ) u_meta_ram (
      .clock   (clock),
      .wr_en   (meta_wr_en),
      .wr_addr (meta_wr_addr),
      .wr_data (meta_wr_data),
      .rd_en   (meta_rd_en),
      .rd_addr (req_bucket),
      .rd_data (meta_rd_data)
   );

   hbp_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (ENTRY_DEPTH)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (entry_wr_en),
      .wr_addr (entry_wr_addr),
      .wr_data ({nonce_ff, suffix_ff}),
      .rd_en   (entry_rd_en),
      .rd_addr (entry_rd_addr),
      .rd_data (entry_rd_data)
   );

   // ---------------------------------------------------------- result port
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {2'b00, out_nonce_ff, out_suffix_ff, out_index_ff};
   assign rsp_tuser  = {out_ovf_ff, out_entry_valid_ff};
   assign rsp_tlast  = out_last_ff;

endmodule
